FILE: src/fitzhugh_nagumo_cell_update_top_macros.svh
// assertion macros shared by the cell update block
`ifndef FITZHUGH_NAGUMO_CELL_UPDATE_TOP_MACROS_SVH
`define FITZHUGH_NAGUMO_CELL_UPDATE_TOP_MACROS_SVH

// same-cycle implication, clocked on aclk, off during reset
`define FNC_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on aclk, off during reset
`define FNC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/fnc_pkg.sv
// shared types, constants and saturating arithmetic for the cell update block
`timescale 1ns / 1ps

package fnc_pkg;

    // datapath and field width of voltages, currents and coefficients
    localparam int DW     = 32;
    // particle mass and time step width
    localparam int MASS_W = 31;
    // byte address width of the register port
    localparam int CFG_AW = 5;

    typedef enum logic [2:0] {
        REG_REST,
        REG_INV_SPAN,
        REG_THRESH,
        REG_COEF1,
        REG_COEF2,
        REG_COEF3,
        REG_COEF4,
        REG_TIME_STEP
    } reg_idx_t;

    // value plus clip flag
    typedef struct packed {
        logic                 sat;
        logic signed [DW-1:0] val;
    } res_t;

    // raw product magnitude and its sign
    typedef struct packed {
        logic              neg;
        logic [2*DW-1:0]   prod;
    } mul_raw_t;

    // per-particle fields carried alongside the math
    typedef struct packed {
        logic signed [DW-1:0] ion;
        logic signed [DW-1:0] rec;
        logic [MASS_W-1:0]    mass;
        logic                 last;
    } cry_t;

    // one result beat
    typedef struct packed {
        logic signed [DW-1:0] ion;
        logic signed [DW-1:0] rec;
        logic                 last;
        logic                 sat;
    } out_t;

    localparam logic signed [DW-1:0] MAX_VAL = {1'b0, {(DW-1){1'b1}}};
    localparam logic signed [DW-1:0] MIN_VAL = {1'b1, {(DW-1){1'b0}}};

    function automatic logic [DW-1:0] mag_of(input logic signed [DW-1:0] a);
        return a[DW-1] ? (~$unsigned(a) + DW'(1)) : $unsigned(a);
    endfunction

    // magnitude product only; rounding is applied after the product is registered
    function automatic mul_raw_t fmul_raw(input logic signed [DW-1:0] a,
                                          input logic signed [DW-1:0] b);
        mul_raw_t r;
        r.neg  = a[DW-1] ^ b[DW-1];
        r.prod = (2*DW)'(mag_of(a)) * (2*DW)'(mag_of(b));
        return r;
    endfunction

    // saturating add or subtract
    function automatic res_t sadd_sat(input logic signed [DW-1:0] a,
                                      input logic signed [DW-1:0] b,
                                      input logic                 sub);
        logic signed [DW:0] s;
        res_t               r;
        s = sub ? ({a[DW-1], a} - {b[DW-1], b}) : ({a[DW-1], a} + {b[DW-1], b});
        r.sat = s[DW] != s[DW-1];
        if (r.sat) begin
            r.val = s[DW] ? MIN_VAL : MAX_VAL;
        end else begin
            r.val = s[DW-1:0];
        end
        return r;
    endfunction

endpackage

FILE: src/fnc_div.sv
// pipelined restoring divider: round(num * 2^frac / mass), saturated
`timescale 1ns / 1ps

module fnc_div #(
    parameter int FRAC_BITS = 16
) (
    input  logic                          aclk,
    input  logic                          en,
    input  logic signed [fnc_pkg::DW-1:0] num,
    input  logic [fnc_pkg::MASS_W-1:0]    mass,
    output fnc_pkg::res_t                 quo
);
    import fnc_pkg::*;

    // one quotient bit per stage
    localparam int NQ = DW + FRAC_BITS;
    localparam logic [NQ:0] LIM_NEG = (NQ+1)'(1) << (DW - 1);
    localparam logic [NQ:0] LIM_POS = LIM_NEG - (NQ+1)'(1);

    logic [MASS_W-1:0] rem_reg [0:NQ];
    logic [NQ-1:0]     sh_reg  [0:NQ];
    logic [MASS_W-1:0] ms_reg  [0:NQ];
    logic              neg_reg [0:NQ];
    logic              zro_reg [0:NQ];
    res_t              res_reg;
    res_t              res_next;

    logic              rup;
    logic [NQ:0]       qr;
    logic [NQ:0]       lim;
    logic [DW-1:0]     mag;

    // entry: magnitude, scaled dividend in the shift register
    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0] <= '0;
            sh_reg[0]  <= {mag_of(num), {FRAC_BITS{1'b0}}};
            ms_reg[0]  <= mass;
            neg_reg[0] <= num[DW-1];
            zro_reg[0] <= num == '0;
        end
    end

    // dividend bits shift out the top, quotient bits shift in at the bottom
    for (genvar k = 0; k < NQ; k++) begin : g_step
        logic [MASS_W:0] rs;
        logic [MASS_W:0] df;
        logic            ge;

        assign rs = {rem_reg[k], sh_reg[k][NQ-1]};
        assign ge = rs >= {1'b0, ms_reg[k]};
        assign df = rs - {1'b0, ms_reg[k]};

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k+1] <= ge ? df[MASS_W-1:0] : rs[MASS_W-1:0];
                sh_reg[k+1]  <= {sh_reg[k][NQ-2:0], ge};
                ms_reg[k+1]  <= ms_reg[k];
                neg_reg[k+1] <= neg_reg[k];
                zro_reg[k+1] <= zro_reg[k];
            end
        end
    end

    // round half away from zero, clip, restore sign
    always_comb begin
        rup = {rem_reg[NQ], 1'b0} >= {1'b0, ms_reg[NQ]};
        qr  = {1'b0, sh_reg[NQ]} + (NQ+1)'(rup);
        lim = neg_reg[NQ] ? LIM_NEG : LIM_POS;
        res_next.sat = !zro_reg[NQ] && (qr > lim);
        mag = (qr > lim) ? lim[DW-1:0] : qr[DW-1:0];
        if (zro_reg[NQ]) begin
            res_next.val = '0;
        end else begin
            res_next.val = $signed(neg_reg[NQ] ? (~mag + DW'(1)) : mag);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            res_reg <= res_next;
        end
    end

    assign quo = res_reg;

endmodule

FILE: src/fitzhugh_nagumo_cell_update_top.sv
// top level of the cell update block: one explicit euler step per particle
//
// channels: particles come in on the s_ valid/ready channel, one beat per
// particle; each beat makes exactly one result beat on the m_ valid/ready
// channel, in order. coefficients sit behind an apb-style port (byte address
// 4*i for register i, pready tied high); the user must see that they are written
// only while the block is idle, which the block itself does not enforce.
// throughput: one particle per cycle, sustained while m_ready is held high.
// pipeline: twelve front stages for the fixed-point multiplies and adds, then
// the divide by mass, which resolves one quotient bit per stage over
// FRAC_BITS + 32 stages, then the final add and the output register.
// reset: aresetn clears all valid bits and loads the register defaults; the
// pipeline comes out of reset empty and ready.
// receiver stall: a one-beat skid register catches the beat that leaves the
// pipeline while m_ready is low; once it is full s_ready drops and the whole
// pipeline freezes, so nothing is lost or repeated.
`timescale 1ns / 1ps
`include "fitzhugh_nagumo_cell_update_top_macros.svh"

module fitzhugh_nagumo_cell_update_top #(
    parameter int FRAC_BITS = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,

    // register port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [fnc_pkg::CFG_AW-1:0]    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,

    // particle beats
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [fnc_pkg::DW-1:0] s_membrane_voltage,
    input  logic signed [fnc_pkg::DW-1:0] s_ion_current,
    input  logic signed [fnc_pkg::DW-1:0] s_recovery,
    input  logic [fnc_pkg::MASS_W-1:0]    s_particle_mass,
    input  logic                          s_last_particle,

    // result beats
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [fnc_pkg::DW-1:0] m_new_ion_current,
    output logic signed [fnc_pkg::DW-1:0] m_new_recovery,
    output logic                          m_last_out,
    output logic                          m_saturated
);
    import fnc_pkg::*;

    localparam int NFRONT  = 12;
    localparam int DIV_LAT = DW + FRAC_BITS + 2;
    localparam int FIN     = NFRONT + DIV_LAT + 1;

    localparam logic [2*DW-1:0]      RND_HALF = (2*DW)'(1) << (FRAC_BITS - 1);
    localparam logic [2*DW-1:0]      LIM_NEG  = (2*DW)'(1) << (DW - 1);
    localparam logic [2*DW-1:0]      LIM_POS  = LIM_NEG - (2*DW)'(1);
    localparam logic signed [DW-1:0] ONE_FX   = DW'(1) << FRAC_BITS;

    // second half of a fixed-point multiply: round, scale, clip, sign
    function automatic res_t fmul_fin(input mul_raw_t r);
        logic [2*DW-1:0] rnd;
        logic [2*DW-1:0] lim;
        logic [DW-1:0]   mag;
        res_t            o;
        rnd   = (r.prod + RND_HALF) >> FRAC_BITS;
        lim   = r.neg ? LIM_NEG : LIM_POS;
        o.sat = rnd > lim;
        mag   = o.sat ? lim[DW-1:0] : rnd[DW-1:0];
        o.val = $signed(r.neg ? (~mag + DW'(1)) : mag);
        return o;
    endfunction

    // ---------------- register port ----------------
    logic signed [DW-1:0] cfg_rest_reg;
    logic signed [DW-1:0] cfg_inv_reg;
    logic signed [DW-1:0] cfg_thr_reg;
    logic signed [DW-1:0] cfg_c1_reg;
    logic signed [DW-1:0] cfg_c2_reg;
    logic signed [DW-1:0] cfg_c3_reg;
    logic signed [DW-1:0] cfg_c4_reg;
    logic [MASS_W-1:0]    cfg_dt_reg;
    logic signed [DW-1:0] dt_s;
    reg_idx_t             reg_idx;
    logic                 cfg_wr;

    assign pready  = 1'b1;
    assign reg_idx = reg_idx_t'(paddr[CFG_AW-1:2]);
    assign cfg_wr  = psel && penable && pwrite;
    assign dt_s    = $signed({1'b0, cfg_dt_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_rest_reg <= '0;
            cfg_inv_reg  <= DW'(65536);
            cfg_thr_reg  <= '0;
            cfg_c1_reg   <= '0;
            cfg_c2_reg   <= '0;
            cfg_c3_reg   <= '0;
            cfg_c4_reg   <= '0;
            cfg_dt_reg   <= MASS_W'(328);
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_REST:      cfg_rest_reg <= $signed(pwdata);
                REG_INV_SPAN:  cfg_inv_reg  <= $signed(pwdata);
                REG_THRESH:    cfg_thr_reg  <= $signed(pwdata);
                REG_COEF1:     cfg_c1_reg   <= $signed(pwdata);
                REG_COEF2:     cfg_c2_reg   <= $signed(pwdata);
                REG_COEF3:     cfg_c3_reg   <= $signed(pwdata);
                REG_COEF4:     cfg_c4_reg   <= $signed(pwdata);
                REG_TIME_STEP: cfg_dt_reg   <= pwdata[MASS_W-1:0];
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_REST:      prdata = $unsigned(cfg_rest_reg);
            REG_INV_SPAN:  prdata = $unsigned(cfg_inv_reg);
            REG_THRESH:    prdata = $unsigned(cfg_thr_reg);
            REG_COEF1:     prdata = $unsigned(cfg_c1_reg);
            REG_COEF2:     prdata = $unsigned(cfg_c2_reg);
            REG_COEF3:     prdata = $unsigned(cfg_c3_reg);
            REG_COEF4:     prdata = $unsigned(cfg_c4_reg);
            REG_TIME_STEP: prdata = {1'b0, cfg_dt_reg};
        endcase
    end

    // ---------------- pipeline control ----------------
    // everything advances together; only a full skid register holds it
    logic en;
    logic vld_reg [1:FIN];
    cry_t cry_reg [1:FIN-1];
    logic flg_reg [1:FIN-1];
    logic sat_stg [1:FIN-1];

    assign s_ready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 1; k <= FIN; k++) begin
                vld_reg[k] <= 1'b0;
            end
        end else if (en) begin
            vld_reg[1] <= s_valid;
            for (int k = 2; k <= FIN; k++) begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    // ---------------- front stages ----------------
    // s1: v - rest, start the products that need only w and registers
    logic signed [DW-1:0] s1_d0_reg;
    mul_raw_t             s1_e_reg, s1_g_reg, s1_k_reg;
    // s2: start u, finish c4*w, c2*w, dt*c3
    mul_raw_t             s2_u_reg;
    logic signed [DW-1:0] s2_e_reg, s2_g_reg, s2_k_reg;
    // s3: u
    logic signed [DW-1:0] s3_u_reg, s3_e_reg, s3_g_reg, s3_k_reg;
    // s4: u - thr, u - 1, u - c4*w, start c1*u
    mul_raw_t             s4_a_reg;
    logic signed [DW-1:0] s4_b_reg, s4_c_reg, s4_rec_reg, s4_g_reg, s4_k_reg;
    // s5: c1*u, start recovery numerator
    logic signed [DW-1:0] s5_a_reg, s5_b_reg, s5_c_reg, s5_g_reg;
    mul_raw_t             s5_p2_reg;
    // s6..s9: cubic term
    mul_raw_t             s6_ab_reg;
    logic signed [DW-1:0] s6_p2_reg, s6_c_reg, s6_g_reg;
    logic signed [DW-1:0] s7_ab_reg, s7_c_reg, s7_g_reg, s7_p2_reg;
    mul_raw_t             s8_cub_reg;
    logic signed [DW-1:0] s8_g_reg, s8_p2_reg;
    logic signed [DW-1:0] s9_cub_reg, s9_g_reg, s9_p2_reg;
    // s10..s12: drive and current numerator
    logic signed [DW-1:0] s10_drv_reg, s10_p2_reg;
    mul_raw_t             s11_p1_reg;
    logic signed [DW-1:0] s11_p2_reg;
    logic signed [DW-1:0] s12_p1_reg, s12_p2_reg;

    res_t d0_r, e_r, g_r, k_r, u_r, b_r, c_r, rec_r;
    res_t a_r, p2_r, ab_r, cub_r, drv_r, p1_r;

    always_comb begin
        d0_r  = sadd_sat(s_membrane_voltage, cfg_rest_reg, 1'b1);
        e_r   = fmul_fin(s1_e_reg);
        g_r   = fmul_fin(s1_g_reg);
        k_r   = fmul_fin(s1_k_reg);
        u_r   = fmul_fin(s2_u_reg);
        b_r   = sadd_sat(s3_u_reg, cfg_thr_reg, 1'b1);
        c_r   = sadd_sat(s3_u_reg, ONE_FX, 1'b1);
        rec_r = sadd_sat(s3_u_reg, s3_e_reg, 1'b1);
        a_r   = fmul_fin(s4_a_reg);
        p2_r  = fmul_fin(s5_p2_reg);
        ab_r  = fmul_fin(s6_ab_reg);
        cub_r = fmul_fin(s8_cub_reg);
        drv_r = sadd_sat(s9_cub_reg, s9_g_reg, 1'b0);
        p1_r  = fmul_fin(s11_p1_reg);

        // clip events picked up by each stage
        for (int k = 1; k < FIN; k++) begin
            sat_stg[k] = 1'b0;
        end
        sat_stg[1]  = d0_r.sat;
        sat_stg[2]  = e_r.sat | g_r.sat | k_r.sat;
        sat_stg[3]  = u_r.sat;
        sat_stg[4]  = b_r.sat | c_r.sat | rec_r.sat;
        sat_stg[5]  = a_r.sat;
        sat_stg[6]  = p2_r.sat;
        sat_stg[7]  = ab_r.sat;
        sat_stg[9]  = cub_r.sat;
        sat_stg[10] = drv_r.sat;
        sat_stg[12] = p1_r.sat;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_d0_reg   <= d0_r.val;
            s1_e_reg    <= fmul_raw(cfg_c4_reg, s_recovery);
            s1_g_reg    <= fmul_raw(cfg_c2_reg, s_recovery);
            s1_k_reg    <= fmul_raw(dt_s, cfg_c3_reg);

            s2_u_reg    <= fmul_raw(s1_d0_reg, cfg_inv_reg);
            s2_e_reg    <= e_r.val;
            s2_g_reg    <= g_r.val;
            s2_k_reg    <= k_r.val;

            s3_u_reg    <= u_r.val;
            s3_e_reg    <= s2_e_reg;
            s3_g_reg    <= s2_g_reg;
            s3_k_reg    <= s2_k_reg;

            s4_a_reg    <= fmul_raw(cfg_c1_reg, s3_u_reg);
            s4_b_reg    <= b_r.val;
            s4_c_reg    <= c_r.val;
            s4_rec_reg  <= rec_r.val;
            s4_g_reg    <= s3_g_reg;
            s4_k_reg    <= s3_k_reg;

            s5_a_reg    <= a_r.val;
            s5_p2_reg   <= fmul_raw(s4_k_reg, s4_rec_reg);
            s5_b_reg    <= s4_b_reg;
            s5_c_reg    <= s4_c_reg;
            s5_g_reg    <= s4_g_reg;

            s6_ab_reg   <= fmul_raw(s5_a_reg, s5_b_reg);
            s6_p2_reg   <= p2_r.val;
            s6_c_reg    <= s5_c_reg;
            s6_g_reg    <= s5_g_reg;

            s7_ab_reg   <= ab_r.val;
            s7_c_reg    <= s6_c_reg;
            s7_g_reg    <= s6_g_reg;
            s7_p2_reg   <= s6_p2_reg;

            s8_cub_reg  <= fmul_raw(s7_ab_reg, s7_c_reg);
            s8_g_reg    <= s7_g_reg;
            s8_p2_reg   <= s7_p2_reg;

            s9_cub_reg  <= cub_r.val;
            s9_g_reg    <= s8_g_reg;
            s9_p2_reg   <= s8_p2_reg;

            s10_drv_reg <= drv_r.val;
            s10_p2_reg  <= s9_p2_reg;

            s11_p1_reg  <= fmul_raw(dt_s, s10_drv_reg);
            s11_p2_reg  <= s10_p2_reg;

            s12_p1_reg  <= p1_r.val;
            s12_p2_reg  <= s11_p2_reg;

            // particle fields and the running clip flag ride along
            cry_reg[1] <= '{ion: s_ion_current, rec: s_recovery,
                            mass: s_particle_mass, last: s_last_particle};
            flg_reg[1] <= sat_stg[1];
            for (int k = 2; k < FIN; k++) begin
                cry_reg[k] <= cry_reg[k-1];
                flg_reg[k] <= flg_reg[k-1] | sat_stg[k];
            end
        end
    end

    // ---------------- divide by mass ----------------
    res_t q1, q2;

    fnc_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div_ion (
        .aclk (aclk),
        .en   (en),
        .num  (s12_p1_reg),
        .mass (cry_reg[NFRONT].mass),
        .quo  (q1)
    );

    fnc_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div_rec (
        .aclk (aclk),
        .en   (en),
        .num  (s12_p2_reg),
        .mass (cry_reg[NFRONT].mass),
        .quo  (q2)
    );

    // ---------------- final add ----------------
    res_t ion_r, w_r;
    out_t fin_next;
    out_t fin_reg;

    // datapath is 32 bits wide, so the final clamp to the field range adds nothing
    always_comb begin
        ion_r = sadd_sat(cry_reg[FIN-1].ion, q1.val, 1'b0);
        w_r   = sadd_sat(cry_reg[FIN-1].rec, q2.val, 1'b0);
        fin_next.ion  = ion_r.val;
        fin_next.rec  = w_r.val;
        fin_next.last = cry_reg[FIN-1].last;
        fin_next.sat  = flg_reg[FIN-1] | q1.sat | q2.sat | ion_r.sat | w_r.sat;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            fin_reg <= fin_next;
        end
    end

    // ---------------- output register and skid ----------------
    logic out_vld_reg, out_vld_next;
    logic skd_vld_reg, skd_vld_next;
    out_t out_reg, out_next;
    out_t skd_reg, skd_next;
    logic push;

    assign en   = !skd_vld_reg;
    assign push = en && vld_reg[FIN];

    always_comb begin
        out_vld_next = out_vld_reg;
        skd_vld_next = skd_vld_reg;
        out_next     = out_reg;
        skd_next     = skd_reg;
        if (!out_vld_reg || m_ready) begin
            if (skd_vld_reg) begin
                // drain the skid first; pipeline is frozen this cycle
                out_next     = skd_reg;
                out_vld_next = 1'b1;
                skd_vld_next = 1'b0;
            end else begin
                out_next     = fin_reg;
                out_vld_next = push;
            end
        end else if (push) begin
            skd_next     = fin_reg;
            skd_vld_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
            skd_vld_reg <= 1'b0;
        end else begin
            out_vld_reg <= out_vld_next;
            skd_vld_reg <= skd_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg <= out_next;
        skd_reg <= skd_next;
    end

    assign m_valid           = out_vld_reg;
    assign m_new_ion_current = out_reg.ion;
    assign m_new_recovery    = out_reg.rec;
    assign m_last_out        = out_reg.last;
    assign m_saturated       = out_reg.sat;

    // ---------------- assertions ----------------
    `FNC_ASSERT_SAME(a_skid_behind_out, skd_vld_reg, out_vld_reg, "skid full with output empty")
    `FNC_ASSERT_SAME(a_skid_fill, $rose(skd_vld_reg), $past(out_vld_reg && !m_ready), "skid fill")
    `FNC_ASSERT_NEXT(a_freeze, !s_ready, vld_reg[FIN] == $past(vld_reg[FIN]), "moved while frozen")

endmodule

FILE: tb/tb_fitzhugh_nagumo_cell_update_top.sv
// self-checking testbench of the fitzhugh-nagumo cell update block
`timescale 1ns / 1ps

module tb_fitzhugh_nagumo_cell_update_top;
    import fnc_pkg::*;

    localparam int FRAC           = 16;
    // beat-in to beat-out latency of the block at this FRAC
    localparam int PIPE_LATENCY   = FRAC + 48;
    // receiver hold-off, long enough to fill the pipeline and the skid register
    localparam int HOLD_CYCLES    = 400;
    // cycles with no beat on either channel before the run is abandoned
    localparam int WATCHDOG_LIMIT = 4000;

    localparam longint SAT_HI = 64'sd2147483647;
    localparam longint SAT_LO = -64'sd2147483648;
    localparam longint Q_ONE  = 64'sd1 << FRAC;

    // one particle beat as offered on the input channel
    typedef struct packed {
        logic signed [DW-1:0] volt;
        logic signed [DW-1:0] ion;
        logic signed [DW-1:0] rec;
        logic [MASS_W-1:0]    mass;
        logic                 last;
    } particle_t;

    logic                 aclk;
    logic                 aresetn            = 1'b0;
    logic                 psel               = 1'b0;
    logic                 penable            = 1'b0;
    logic                 pwrite             = 1'b0;
    logic [CFG_AW-1:0]    paddr              = '0;
    logic [31:0]          pwdata             = '0;
    logic [31:0]          prdata;
    logic                 pready;
    logic                 s_valid            = 1'b0;
    logic                 s_ready;
    logic signed [DW-1:0] s_membrane_voltage = '0;
    logic signed [DW-1:0] s_ion_current      = '0;
    logic signed [DW-1:0] s_recovery         = '0;
    logic [MASS_W-1:0]    s_particle_mass    = '0;
    logic                 s_last_particle    = 1'b0;
    logic                 m_valid;
    logic                 m_ready            = 1'b0;
    logic signed [DW-1:0] m_new_ion_current;
    logic signed [DW-1:0] m_new_recovery;
    logic                 m_last_out;
    logic                 m_saturated;

    fitzhugh_nagumo_cell_update_top #(
        .FRAC_BITS(FRAC)
    ) i_dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_membrane_voltage (s_membrane_voltage),
        .s_ion_current      (s_ion_current),
        .s_recovery         (s_recovery),
        .s_particle_mass    (s_particle_mass),
        .s_last_particle    (s_last_particle),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_new_ion_current  (m_new_ion_current),
        .m_new_recovery     (m_new_recovery),
        .m_last_out         (m_last_out),
        .m_saturated        (m_saturated)
    );

    // shadow copy of the coefficient registers, reset values
    longint rest_q = 0;
    longint inv_q  = 65536;
    longint thr_q  = 0;
    longint c1_q   = 0;
    longint c2_q   = 0;
    longint c3_q   = 0;
    longint c4_q   = 0;
    longint dt_q   = 328;

    // any clip seen while computing the current particle
    bit        clip_seen;

    particle_t particle_queue[$];
    out_t      predicted_updates[$];
    int        mismatches    = 0;
    int        quiet_cycles  = 0;
    int        send_idle_pct = 34;
    int        recv_idle_pct = 84;
    int        hold_reqs     = 0;
    int        hold_seen     = 0;
    int        hold_left     = 0;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // ---------------------------------------------------------------
    // fixed-point arithmetic of the update, 32-bit saturating datapath
    // ---------------------------------------------------------------

    function automatic longint clip(longint x);
        if (x > SAT_HI) begin
            clip_seen = 1'b1;
            return SAT_HI;
        end
        if (x < SAT_LO) begin
            clip_seen = 1'b1;
            return SAT_LO;
        end
        return x;
    endfunction

    // operands are always in 32-bit range, so the 64-bit sum is exact
    function automatic longint add_sat(longint a, longint b);
        return clip(a + b);
    endfunction

    function automatic longint sub_sat(longint a, longint b);
        return clip(a - b);
    endfunction

    // sign and magnitude back to a value; the negative side reaches one further
    function automatic longint mag_pack(bit neg, bit [63:0] mag);
        bit [63:0] lim;
        lim = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
        if (mag > lim) begin
            clip_seen = 1'b1;
            mag = lim;
        end
        return neg ? -longint'(mag) : longint'(mag);
    endfunction

    // product of magnitudes, rounded half away from zero, then scaled back
    function automatic longint qmul(longint a, longint b);
        bit [63:0] x;
        bit [63:0] y;
        x = (a < 0) ? -a : a;
        y = (b < 0) ? -b : b;
        return mag_pack((a < 0) != (b < 0), (x * y + (64'd1 << (FRAC - 1))) >> FRAC);
    endfunction

    // scaled quotient by particle mass, rounded half away from zero
    function automatic longint qdiv(longint num, bit [63:0] m);
        bit [63:0] n;
        bit [63:0] q;
        bit [63:0] r;
        if (m == 0) begin
            // zero mass: zero stays zero, anything else pins to the rail
            if (num == 0) return 0;
            clip_seen = 1'b1;
            return (num < 0) ? SAT_LO : SAT_HI;
        end
        n = (num < 0) ? -num : num;
        n = n << FRAC;
        q = n / m;
        r = n % m;
        if ((r << 1) >= m) q = q + 1;
        return mag_pack(num < 0, q);
    endfunction

    // one euler step of the cell model, evaluated in the block's order
    function automatic out_t euler_step(particle_t p);
        longint u;
        longint cubic;
        longint drive;
        longint decay;
        bit [63:0] m;
        out_t r;
        clip_seen = 1'b0;
        m     = {33'b0, p.mass};
        u     = qmul(sub_sat(longint'(p.volt), rest_q), inv_q);
        cubic = qmul(qmul(qmul(c1_q, u), sub_sat(u, thr_q)), sub_sat(u, Q_ONE));
        drive = add_sat(cubic, qmul(c2_q, longint'(p.rec)));
        r.ion = DW'(add_sat(longint'(p.ion), qdiv(qmul(dt_q, drive), m)));
        decay = sub_sat(u, qmul(c4_q, longint'(p.rec)));
        r.rec = DW'(add_sat(longint'(p.rec), qdiv(qmul(qmul(dt_q, c3_q), decay), m)));
        r.last = p.last;
        r.sat  = clip_seen;
        return r;
    endfunction

    // ---------------------------------------------------------------
    // stimulus helpers
    // ---------------------------------------------------------------

    function automatic logic signed [DW-1:0] corner_value();
        case ($urandom_range(6))
            0:       return MAX_VAL;
            1:       return MIN_VAL;
            2:       return '0;
            3:       return 32'sd1;
            4:       return -32'sd1;
            5:       return 32'sd65536;
            default: return -32'sd65536;
        endcase
    endfunction

    // mostly physically sensible particles around the resting level,
    // the rest full-range noise and corner values
    function automatic particle_t draw_particle();
        particle_t p;
        int        pick;
        pick = $urandom_range(99);
        if (pick < 60) begin
            p.volt = DW'(rest_q + int'($urandom_range(262144)) - 131072);
            p.ion  = int'($urandom_range(524288)) - 262144;
            p.rec  = int'($urandom_range(524288)) - 262144;
            p.mass = MASS_W'($urandom_range(262144, 16384));
            p.last = ($urandom_range(9) == 0);
        end else if (pick < 85) begin
            p.volt = $urandom;
            p.ion  = $urandom;
            p.rec  = $urandom;
            p.mass = MASS_W'($urandom);
            p.last = 1'($urandom_range(1));
        end else begin
            p.volt = corner_value();
            p.ion  = corner_value();
            p.rec  = corner_value();
            case ($urandom_range(3))
                0:       p.mass = '0;
                1:       p.mass = 31'd1;
                2:       p.mass = '1;
                default: p.mass = 31'd65536;
            endcase
            p.last = 1'($urandom_range(1));
        end
        return p;
    endfunction

    task automatic push_particle(input logic signed [DW-1:0] volt,
                                 input logic signed [DW-1:0] ion,
                                 input logic signed [DW-1:0] rec,
                                 input logic [MASS_W-1:0]    mass,
                                 input logic                 last);
        particle_t p;
        p.volt = volt;
        p.ion  = ion;
        p.rec  = rec;
        p.mass = mass;
        p.last = last;
        particle_queue.insert(particle_queue.size(), p);
    endtask

    task automatic push_random(input int count);
        repeat (count) particle_queue.insert(particle_queue.size(), draw_particle());
    endtask

    // sender stays quiet until every predicted result has come back
    task automatic wait_drained();
        while (particle_queue.size() != 0 || s_valid || predicted_updates.size() != 0)
            @(posedge aclk);
    endtask

    // apb write: setup cycle, access cycle, register lands at the access edge
    task automatic cfg_write(input reg_idx_t idx, input logic [31:0] val);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_REST:      rest_q = longint'($signed(val));
            REG_INV_SPAN:  inv_q  = longint'($signed(val));
            REG_THRESH:    thr_q  = longint'($signed(val));
            REG_COEF1:     c1_q   = longint'($signed(val));
            REG_COEF2:     c2_q   = longint'($signed(val));
            REG_COEF3:     c3_q   = longint'($signed(val));
            REG_COEF4:     c4_q   = longint'($signed(val));
            REG_TIME_STEP: dt_q   = longint'({1'b0, val[30:0]});
            default: ;
        endcase
    endtask

    // coefficients in a realistic band, so most results stay unclipped
    task automatic cfg_moderate();
        cfg_write(REG_REST,      int'($urandom_range(131072)) - 65536);
        cfg_write(REG_INV_SPAN,  $urandom_range(131072, 32768));
        cfg_write(REG_THRESH,    $urandom_range(32768, 6554));
        cfg_write(REG_COEF1,     int'($urandom_range(1048576)) - 524288);
        cfg_write(REG_COEF2,     int'($urandom_range(262144)) - 131072);
        cfg_write(REG_COEF3,     int'($urandom_range(262144)) - 131072);
        cfg_write(REG_COEF4,     int'($urandom_range(262144)) - 131072);
        cfg_write(REG_TIME_STEP, $urandom_range(6554, 64));
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch on %s: got %h, expected %h at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    // ---------------------------------------------------------------
    // driver: one beat in flight, payload held until accepted
    // ---------------------------------------------------------------
    always @(posedge aclk) begin : driver
        particle_t nxt;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (particle_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                nxt = particle_queue.pop_front();
                s_valid            <= 1'b1;
                s_membrane_voltage <= nxt.volt;
                s_ion_current      <= nxt.ion;
                s_recovery         <= nxt.rec;
                s_particle_mass    <= nxt.mass;
                s_last_particle    <= nxt.last;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // receiver: random back-pressure, plus a long hold-off on request
    always @(posedge aclk) begin : receiver
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_seen != hold_reqs) begin
            hold_seen = hold_reqs;
            hold_left = HOLD_CYCLES;
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // monitor: predict on every accepted particle, check every result beat,
    // and watch for the handshake going quiet
    always @(posedge aclk) begin : monitor
        particle_t seen;
        out_t      want;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                seen.volt = s_membrane_voltage;
                seen.ion  = s_ion_current;
                seen.rec  = s_recovery;
                seen.mass = s_particle_mass;
                seen.last = s_last_particle;
                predicted_updates.insert(predicted_updates.size(), euler_step(seen));
            end
            if (m_valid && m_ready) begin
                if (predicted_updates.size() == 0) begin
                    report_mismatch("result beat with nothing outstanding",
                                    m_new_ion_current, '0);
                end else begin
                    want = predicted_updates.pop_front();
                    if (m_new_ion_current !== want.ion)
                        report_mismatch("new_ion_current", m_new_ion_current, want.ion);
                    if (m_new_recovery !== want.rec)
                        report_mismatch("new_recovery", m_new_recovery, want.rec);
                    if (m_last_out !== want.last)
                        report_mismatch("last_out", 32'(m_last_out), 32'(want.last));
                    if (m_saturated !== want.sat)
                        report_mismatch("saturated", 32'(m_saturated), 32'(want.sat));
                end
            end
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles = quiet_cycles + 1;
                if (quiet_cycles >= WATCHDOG_LIMIT) begin
                    $display("watchdog: no beat for %0d cycles", WATCHDOG_LIMIT);
                    $display("FAIL");
                    $finish;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // test sequence
    // ---------------------------------------------------------------
    initial begin : sequencer
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // phase 1: sender idles a third of the time, receiver most of it
        send_idle_pct = 34;
        recv_idle_pct = 84;

        // a few particles at the reset coefficients
        push_random(4);
        wait_drained();

        // directed particles under a realistic setting
        cfg_moderate();
        // zero mass with a zero numerator: no clip
        push_particle(DW'(rest_q), '0, '0, '0, 1'b0);
        // zero mass with a nonzero numerator: pinned to the rail
        push_particle(DW'(rest_q + 65536), '0, 32'sd65536, '0, 1'b1);
        push_particle(MAX_VAL, MAX_VAL, MAX_VAL, '1, 1'b1);
        push_particle(MIN_VAL, MIN_VAL, MIN_VAL, 31'd1, 1'b0);
        push_particle(MIN_VAL, MAX_VAL, MIN_VAL, '0, 1'b1);
        push_particle(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 31'h2AAA_AAAA, 1'b0);
        push_particle(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 31'h5555_5555, 1'b1);
        // current right at the top, so a positive update clips it
        push_particle(DW'(rest_q + 32768), MAX_VAL - 1, '0, 31'd1, 1'b0);
        push_particle(DW'(rest_q + 65536), MIN_VAL, MIN_VAL, 31'd1, 1'b0);
        push_particle(DW'(rest_q - 65536), '0, 32'sd65536, 31'd65536, 1'b1);
        // smallest steps, exercises the rounding
        push_particle(DW'(rest_q + 1), -32'sd1, 32'sd1, 31'd1, 1'b0);
        push_particle(DW'(rest_q + 98304), 32'sd12345, -32'sd54321, '1, 1'b0);
        wait_drained();

        // random particles, with a full drain partway through
        push_random(100);
        wait_drained();
        push_random(140);
        wait_drained();

        // phase 2: roles swapped, coefficients at the extremes
        send_idle_pct = 84;
        recv_idle_pct = 34;
        cfg_write(REG_REST,      MIN_VAL);
        cfg_write(REG_INV_SPAN,  MAX_VAL);
        cfg_write(REG_THRESH,    MAX_VAL);
        cfg_write(REG_COEF1,     MIN_VAL);
        cfg_write(REG_COEF2,     MAX_VAL);
        cfg_write(REG_COEF3,     MIN_VAL);
        cfg_write(REG_COEF4,     MAX_VAL);
        // top bit lies beyond the 31-bit step and must be dropped
        cfg_write(REG_TIME_STEP, 32'hFFFF_FFFF);
        push_random(120);
        wait_drained();

        cfg_write(REG_REST,      MAX_VAL);
        cfg_write(REG_INV_SPAN,  MIN_VAL);
        cfg_write(REG_THRESH,    MIN_VAL);
        cfg_write(REG_COEF1,     MAX_VAL);
        cfg_write(REG_COEF2,     MIN_VAL);
        cfg_write(REG_COEF3,     MAX_VAL);
        cfg_write(REG_COEF4,     MIN_VAL);
        cfg_write(REG_TIME_STEP, '0);
        push_random(120);
        wait_drained();

        // phase 3: no idling, then a long receiver hold-off while the
        // sender keeps offering, so the pipeline fills and stalls
        send_idle_pct = 0;
        recv_idle_pct = 0;
        cfg_moderate();
        hold_reqs = hold_reqs + 1;
        push_random(250);
        wait_drained();

        // let any stray beat show up before judging
        repeat (PIPE_LATENCY + 16) @(posedge aclk);
        if (mismatches == 0 && predicted_updates.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
